// ===== design/dht_pkg.sv =====
// Shared types and constants of the double hashing table.
package dht_pkg;

  localparam int OP_W        = 2;
  localparam int NAME_WORD_W = 64;
  localparam int AGE_W       = 8;
  localparam int WEIGHT_W    = 32;
  localparam int HEIGHT_W    = 32;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 7;
  localparam int KEY_W       = 11;
  localparam int KEY_BIT_W   = 4;
  localparam int SLOT_ST_W   = 2;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  localparam logic [SLOT_ST_W-1:0] SLOT_EMPTY    = 2'd0;
  localparam logic [SLOT_ST_W-1:0] SLOT_OCCUPIED = 2'd1;
  localparam logic [SLOT_ST_W-1:0] SLOT_REMOVED  = 2'd2;

  typedef enum logic [2:0] {
    CTL_CLEAR,
    CTL_IDLE,
    CTL_DIV,
    CTL_ISSUE,
    CTL_PROBE,
    CTL_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic clear;
    logic load_req;
    logic div_step;
    logic probe_init;
    logic probe_step;
    logic bad_op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic op_valid;
    logic probe_done;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== design/dht_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/dht_ctrl.sv =====
// Controller state machine of the double hashing table.
module dht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dht_pkg::dp_status_t status,
  output dht_pkg::dp_cmd_t    cmd
);

  dht_pkg::ctl_state_t state_r;
  dht_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dht_pkg::CTL_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      dht_pkg::CTL_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_nxt = dht_pkg::CTL_IDLE;
        end
      end
      dht_pkg::CTL_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = dht_pkg::CTL_DIV;
        end
      end
      dht_pkg::CTL_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = dht_pkg::CTL_ISSUE;
        end
      end
      dht_pkg::CTL_ISSUE: begin
        cmd.probe_init = 1'b1;
        if (status.op_valid) begin
          state_nxt = dht_pkg::CTL_PROBE;
        end else begin
          cmd.bad_op = 1'b1;
          state_nxt  = dht_pkg::CTL_FINISH;
        end
      end
      dht_pkg::CTL_PROBE: begin
        cmd.probe_step = 1'b1;
        if (status.probe_done) begin
          state_nxt = dht_pkg::CTL_FINISH;
        end
      end
      dht_pkg::CTL_FINISH: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = dht_pkg::CTL_IDLE;
        end
      end
      default: begin
        state_nxt = dht_pkg::CTL_CLEAR;
      end
    endcase
  end

endmodule

// ===== design/dht_datapath.sv =====
// Datapath of the double hashing table: key, modulo unit, probe address, slot RAMs, result.
module dht_datapath #(
  parameter int TABLE_SLOTS = 64,
  parameter int NAME_BYTES  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dht_pkg::dp_cmd_t                    cmd,
  output dht_pkg::dp_status_t                 status,
  input  logic                                cfg_we,
  input  logic [dht_pkg::CFG_W-1:0]           cfg_table_size,
  input  logic [dht_pkg::OP_W-1:0]            in_opcode,
  input  logic [dht_pkg::NAME_WORD_W-1:0]     in_name_word,
  input  logic [dht_pkg::AGE_W-1:0]           in_age_in,
  input  logic [dht_pkg::WEIGHT_W-1:0]        in_weight_in,
  input  logic [dht_pkg::HEIGHT_W-1:0]        in_height_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dht_pkg::STATUS_W-1:0]        out_status,
  output logic [$clog2(TABLE_SLOTS)-1:0]      out_slot_index,
  output logic [dht_pkg::AGE_W-1:0]           out_age_out,
  output logic [dht_pkg::WEIGHT_W-1:0]        out_weight_out,
  output logic [dht_pkg::HEIGHT_W-1:0]        out_height_out
);

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int M_W    = $clog2(TABLE_SLOTS + 1);
  localparam int S_W    = IDX_W + 1;
  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int REC_W  = NAME_W + dht_pkg::AGE_W + dht_pkg::WEIGHT_W + dht_pkg::HEIGHT_W;

  // Configuration and latched request.
  logic [dht_pkg::CFG_W-1:0]     table_size_r;
  logic [dht_pkg::OP_W-1:0]      op_r;
  logic [NAME_W-1:0]             name_r;
  logic [dht_pkg::AGE_W-1:0]     age_r;
  logic [dht_pkg::WEIGHT_W-1:0]  weight_r;
  logic [dht_pkg::HEIGHT_W-1:0]  height_r;
  logic [dht_pkg::KEY_W-1:0]     key_r;
  logic [M_W-1:0]                m_r;

  // Modulo unit and probe sequence.
  logic [dht_pkg::KEY_BIT_W-1:0] div_bit_r;
  logic [M_W-1:0]                rem1_r;
  logic [M_W-1:0]                rem2_r;
  logic [IDX_W-1:0]              pos_r;
  logic [IDX_W-1:0]              step_r;
  logic [M_W-1:0]                cnt_r;
  logic [IDX_W-1:0]              clr_cnt_r;

  // Pending result and output register.
  logic [dht_pkg::STATUS_W-1:0]  res_status_r;
  logic [IDX_W-1:0]              res_slot_r;
  logic [dht_pkg::AGE_W-1:0]     res_age_r;
  logic [dht_pkg::WEIGHT_W-1:0]  res_weight_r;
  logic [dht_pkg::HEIGHT_W-1:0]  res_height_r;
  logic                          out_valid_r;
  logic [dht_pkg::STATUS_W-1:0]  out_status_r;
  logic [IDX_W-1:0]              out_slot_r;
  logic [dht_pkg::AGE_W-1:0]     out_age_r;
  logic [dht_pkg::WEIGHT_W-1:0]  out_weight_r;
  logic [dht_pkg::HEIGHT_W-1:0]  out_height_r;

  logic [M_W-1:0]                m_eff;
  logic [dht_pkg::KEY_W-1:0]     key_sum;
  logic [M_W:0]                  t1;
  logic [M_W:0]                  t2;
  logic [M_W:0]                  d1;
  logic [M_W:0]                  d2;
  logic [M_W-1:0]                rem1_nxt;
  logic [M_W-1:0]                rem2_nxt;
  logic [S_W-1:0]                pos_sum;
  logic [IDX_W-1:0]              pos_nxt;
  logic [IDX_W-1:0]              rd_addr;

  logic [dht_pkg::SLOT_ST_W-1:0] st_rd;
  logic [REC_W-1:0]              rec_rd;
  logic [NAME_W-1:0]             rd_name;
  logic [dht_pkg::AGE_W-1:0]     rd_age;
  logic [dht_pkg::WEIGHT_W-1:0]  rd_weight;
  logic [dht_pkg::HEIGHT_W-1:0]  rd_height;

  logic                          is_insert;
  logic                          is_search;
  logic                          hit;
  logic                          stop_empty;
  logic                          probe_last;
  logic                          probe_done;
  logic                          st_we;
  logic [IDX_W-1:0]              st_waddr;
  logic [dht_pkg::SLOT_ST_W-1:0] st_wdata;
  logic                          rec_we;

  // Effective table size, clamped to the legal range.
  always_comb begin
    if (32'(table_size_r) > TABLE_SLOTS) begin
      m_eff = M_W'(TABLE_SLOTS);
    end else if (table_size_r < dht_pkg::CFG_W'(2)) begin
      m_eff = M_W'(2);
    end else begin
      m_eff = M_W'(table_size_r);
    end
  end

  // The key is the sum of the name bytes in use.
  always_comb begin
    key_sum = '0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      key_sum = key_sum + dht_pkg::KEY_W'(in_name_word[8*b +: 8]);
    end
  end

  // One restoring step of key mod m and key mod (m-1), one key bit per cycle.
  always_comb begin
    t1 = {rem1_r, key_r[div_bit_r]};
    t2 = {rem2_r, key_r[div_bit_r]};
    d1 = {1'b0, m_r};
    d2 = {1'b0, m_r - M_W'(1)};
    rem1_nxt = (t1 >= d1) ? M_W'(t1 - d1) : M_W'(t1);
    rem2_nxt = (t2 >= d2) ? M_W'(t2 - d2) : M_W'(t2);
  end

  // Next probe position; pos and step are both below m.
  always_comb begin
    pos_sum = S_W'(pos_r) + S_W'(step_r);
    if (pos_sum >= S_W'(m_r)) begin
      pos_nxt = IDX_W'(pos_sum - S_W'(m_r));
    end else begin
      pos_nxt = IDX_W'(pos_sum);
    end
    rd_addr = cmd.probe_init ? IDX_W'(rem1_r) : pos_nxt;
  end

  assign rd_name   = rec_rd[REC_W-1 -: NAME_W];
  assign rd_age    = rec_rd[dht_pkg::WEIGHT_W + dht_pkg::HEIGHT_W +: dht_pkg::AGE_W];
  assign rd_weight = rec_rd[dht_pkg::HEIGHT_W +: dht_pkg::WEIGHT_W];
  assign rd_height = rec_rd[dht_pkg::HEIGHT_W-1:0];

  // Evaluation of the slot read in this cycle.
  always_comb begin
    is_insert  = (op_r == dht_pkg::OP_INSERT);
    is_search  = (op_r == dht_pkg::OP_SEARCH);
    if (is_insert) begin
      hit = (st_rd == dht_pkg::SLOT_EMPTY) || (st_rd == dht_pkg::SLOT_REMOVED);
    end else begin
      hit = (st_rd == dht_pkg::SLOT_OCCUPIED) && (rd_name == name_r);
    end
    stop_empty = !is_insert && (st_rd == dht_pkg::SLOT_EMPTY);
    probe_last = (cnt_r == m_r - M_W'(1));
    probe_done = hit || stop_empty || probe_last;
  end

  always_comb begin
    st_we    = cmd.clear || (cmd.probe_step && hit && !is_search);
    st_waddr = cmd.clear ? clr_cnt_r : pos_r;
    if (cmd.clear) begin
      st_wdata = dht_pkg::SLOT_EMPTY;
    end else if (is_insert) begin
      st_wdata = dht_pkg::SLOT_OCCUPIED;
    end else begin
      st_wdata = dht_pkg::SLOT_REMOVED;
    end
    rec_we = cmd.probe_step && hit && is_insert;
  end

  dht_ram #(
    .WIDTH (dht_pkg::SLOT_ST_W),
    .DEPTH (TABLE_SLOTS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr (rd_addr),
    .rd_data (st_rd)
  );

  dht_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_SLOTS)
  ) u_record_ram (
    .clk     (clk),
    .wr_en   (rec_we),
    .wr_addr (pos_r),
    .wr_data ({name_r, age_r, weight_r, height_r}),
    .rd_addr (rd_addr),
    .rd_data (rec_rd)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= dht_pkg::TABLE_SIZE_RESET;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_size_r <= cfg_table_size;
      end
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and sequencing registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r      <= in_opcode;
      name_r    <= in_name_word[NAME_W-1:0];
      age_r     <= in_age_in;
      weight_r  <= in_weight_in;
      height_r  <= in_height_in;
      key_r     <= key_sum;
      m_r       <= m_eff;
      div_bit_r <= dht_pkg::KEY_BIT_W'(dht_pkg::KEY_W - 1);
      rem1_r    <= '0;
      rem2_r    <= '0;
    end
    if (cmd.div_step) begin
      rem1_r    <= rem1_nxt;
      rem2_r    <= rem2_nxt;
      div_bit_r <= div_bit_r - dht_pkg::KEY_BIT_W'(1);
    end
    if (cmd.probe_init) begin
      pos_r  <= IDX_W'(rem1_r);
      step_r <= IDX_W'(rem2_r) + IDX_W'(1);
      cnt_r  <= '0;
    end
    if (cmd.probe_step && !probe_done) begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_r + M_W'(1);
    end
    if (cmd.bad_op) begin
      res_status_r <= dht_pkg::STATUS_NOT_FOUND;
      res_slot_r   <= '0;
      res_age_r    <= '0;
      res_weight_r <= '0;
      res_height_r <= '0;
    end else if (cmd.probe_step && probe_done) begin
      if (hit) begin
        res_status_r <= dht_pkg::STATUS_OK;
        res_slot_r   <= pos_r;
        res_age_r    <= is_search ? rd_age : '0;
        res_weight_r <= is_search ? rd_weight : '0;
        res_height_r <= is_search ? rd_height : '0;
      end else begin
        res_status_r <= is_insert ? dht_pkg::STATUS_FULL : dht_pkg::STATUS_NOT_FOUND;
        res_slot_r   <= '0;
        res_age_r    <= '0;
        res_weight_r <= '0;
        res_height_r <= '0;
      end
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_age_r    <= res_age_r;
      out_weight_r <= res_weight_r;
      out_height_r <= res_height_r;
    end
  end

  assign status.clear_last = (clr_cnt_r == IDX_W'(TABLE_SLOTS - 1));
  assign status.div_last   = (div_bit_r == '0);
  assign status.op_valid   = (op_r == dht_pkg::OP_INSERT) || (op_r == dht_pkg::OP_SEARCH) ||
                             (op_r == dht_pkg::OP_REMOVE);
  assign status.probe_done = probe_done;
  assign status.out_busy   = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_age_out    = out_age_r;
  assign out_weight_out = out_weight_r;
  assign out_height_out = out_height_r;

endmodule

// ===== design/double_hash_table.sv =====
// Top level of the open-addressing hash table with double hashing.
//
// Requests arrive on the in_ channel (valid/ready). Each request inserts,
// searches or removes one record keyed by its name; exactly one result comes
// back on the out_ channel (valid/ready) per request, in request order.
// The cfg_ channel writes the table size; it is always ready and should be
// written only while no request is in flight.
//
// One request is processed at a time. After acceptance the key modulo the
// table size and modulo the table size minus one are formed by two restoring
// dividers that run side by side, one key bit per cycle. The probe loop then
// reads one slot per cycle from the slot RAMs, for 1 to table size probes
// (none for an unused opcode). The next request is accepted only once the
// result of the last one has been loaded into the output register.
//
// After reset the slot status RAM is swept to empty, one slot per cycle;
// in_ready stays low during the sweep.
// The result sits in an output register. A new request may be accepted
// while the receiver stalls; its result waits until the register is freed.
module double_hash_table #(
  parameter int TABLE_SLOTS = 64,
  parameter int NAME_BYTES  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dht_pkg::CFG_W-1:0]       cfg_table_size,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dht_pkg::OP_W-1:0]        in_opcode,
  input  logic [dht_pkg::NAME_WORD_W-1:0] in_name_word,
  input  logic [dht_pkg::AGE_W-1:0]       in_age_in,
  input  logic [dht_pkg::WEIGHT_W-1:0]    in_weight_in,
  input  logic [dht_pkg::HEIGHT_W-1:0]    in_height_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dht_pkg::STATUS_W-1:0]    out_status,
  output logic [$clog2(TABLE_SLOTS)-1:0]  out_slot_index,
  output logic [dht_pkg::AGE_W-1:0]       out_age_out,
  output logic [dht_pkg::WEIGHT_W-1:0]    out_weight_out,
  output logic [dht_pkg::HEIGHT_W-1:0]    out_height_out
);

  dht_pkg::dp_cmd_t    cmd;
  dht_pkg::dp_status_t status;

  // The table size register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences the clearing sweep, the modulo set-up, the probe loop and the result hand-off.
  dht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the request, the slot RAMs and the result registers.
  dht_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .NAME_BYTES  (NAME_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid),
    .cfg_table_size (cfg_table_size),
    .in_opcode      (in_opcode),
    .in_name_word   (in_name_word),
    .in_age_in      (in_age_in),
    .in_weight_in   (in_weight_in),
    .in_height_in   (in_height_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_age_out    (out_age_out),
    .out_weight_out (out_weight_out),
    .out_height_out (out_height_out)
  );

endmodule

// ===== design/dht_checker.sv =====
// Port-level checks of the double hashing table and their binding to the top level.
module dht_checker #(
  parameter int SLOT_W = 6
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dht_pkg::STATUS_W-1:0] out_status,
  input logic [SLOT_W-1:0]            out_slot_index,
  input logic [dht_pkg::AGE_W-1:0]    out_age_out,
  input logic [dht_pkg::WEIGHT_W-1:0] out_weight_out,
  input logic [dht_pkg::HEIGHT_W-1:0] out_height_out
);

  // A stalled result stays valid with its status, slot and age held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_slot_index) && $stable(out_age_out))
    else $error("result changed while stalled");

  // A failed request reports no slot and no record.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dht_pkg::STATUS_OK |->
    out_slot_index == '0 && out_age_out == '0 && out_weight_out == '0 &&
    out_height_out == '0)
    else $error("failed request carries data");

  // The slot status sweep blocks requests right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during the reset sweep");

  // Only one request is processed at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind double_hash_table dht_checker #(
  .SLOT_W ($clog2(TABLE_SLOTS))
) u_dht_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_slot_index (out_slot_index),
  .out_age_out    (out_age_out),
  .out_weight_out (out_weight_out),
  .out_height_out (out_height_out)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the double hashing table: directed rows, then random traffic.
module testbench;

  localparam int SLOTS       = 64;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int POOL_SIZE   = 40;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 163;

  // The opcode left free by the package; the block must answer it as not found.
  localparam logic [dht_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [dht_pkg::STATUS_W-1:0] status;
    logic [SLOT_W-1:0]            slot;
    logic [dht_pkg::AGE_W-1:0]    age;
    logic [dht_pkg::WEIGHT_W-1:0] weight;
    logic [dht_pkg::HEIGHT_W-1:0] height;
  } hash_result_t;

  typedef enum logic {ROW_REQUEST, ROW_RESIZE} row_kind_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [dht_pkg::OP_W-1:0]        op;
    logic [dht_pkg::NAME_WORD_W-1:0] name;
    logic [dht_pkg::AGE_W-1:0]       age;
    logic [dht_pkg::WEIGHT_W-1:0]    weight;
    logic [dht_pkg::HEIGHT_W-1:0]    height;
    logic [dht_pkg::CFG_W-1:0]       size;
    logic                            typed;
    hash_result_t                    res;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [dht_pkg::CFG_W-1:0]       cfg_table_size;
  logic                            in_valid;
  logic                            in_ready;
  logic [dht_pkg::OP_W-1:0]        in_opcode;
  logic [dht_pkg::NAME_WORD_W-1:0] in_name_word;
  logic [dht_pkg::AGE_W-1:0]       in_age_in;
  logic [dht_pkg::WEIGHT_W-1:0]    in_weight_in;
  logic [dht_pkg::HEIGHT_W-1:0]    in_height_in;
  logic                            out_valid;
  logic                            out_ready;
  logic [dht_pkg::STATUS_W-1:0]    out_status;
  logic [SLOT_W-1:0]               out_slot_index;
  logic [dht_pkg::AGE_W-1:0]       out_age_out;
  logic [dht_pkg::WEIGHT_W-1:0]    out_weight_out;
  logic [dht_pkg::HEIGHT_W-1:0]    out_height_out;

  // Shadow copy of the table, kept in step with every accepted request.
  logic [dht_pkg::CFG_W-1:0]       model_size;
  logic [dht_pkg::SLOT_ST_W-1:0]   model_state  [SLOTS];
  logic [dht_pkg::KEY_W-1:0]       model_key    [SLOTS];
  logic [dht_pkg::NAME_WORD_W-1:0] model_name   [SLOTS];
  logic [dht_pkg::AGE_W-1:0]       model_age    [SLOTS];
  logic [dht_pkg::WEIGHT_W-1:0]    model_weight [SLOTS];
  logic [dht_pkg::HEIGHT_W-1:0]    model_height [SLOTS];

  hash_result_t                    pending_results [$];
  dir_row_t                        dir_rows [$];
  logic [dht_pkg::NAME_WORD_W-1:0] name_pool [POOL_SIZE];
  logic [dht_pkg::CFG_W-1:0]       phase_size [PHASES] = '{64, 2, 1, 5, 127, 65, 31, 64};

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;

  double_hash_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_table_size (cfg_table_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_name_word   (in_name_word),
    .in_age_in      (in_age_in),
    .in_weight_in   (in_weight_in),
    .in_height_in   (in_height_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_age_out    (out_age_out),
    .out_weight_out (out_weight_out),
    .out_height_out (out_height_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the answer to one request and applies its effect to the
  // shadow table. Probing follows the double hashing sequence: the first
  // slot is key mod m and the stride is 1 + key mod (m - 1).
  function automatic hash_result_t predict_hash_result(
    input logic [dht_pkg::OP_W-1:0]        op,
    input logic [dht_pkg::NAME_WORD_W-1:0] name,
    input logic [dht_pkg::AGE_W-1:0]       age,
    input logic [dht_pkg::WEIGHT_W-1:0]    weight,
    input logic [dht_pkg::HEIGHT_W-1:0]    height
  );
    hash_result_t res;
    int m;
    int key;
    int pos;
    int stride;
    int hit;
    int b;
    int i;
    res = '0;
    res.status = dht_pkg::STATUS_NOT_FOUND;
    // Sizes outside the supported range are clamped, not rejected.
    m = int'(model_size);
    if (m < 2) m = 2;
    if (m > SLOTS) m = SLOTS;
    key = 0;
    for (b = 0; b < 8; b++) key += int'(name[8*b +: 8]);
    pos = key % m;
    stride = 1 + key % (m - 1);
    if (op == dht_pkg::OP_INSERT) begin
      // Duplicates are allowed; the first free or removed slot wins.
      res.status = dht_pkg::STATUS_FULL;
      for (i = 0; i < m; i++) begin
        if (model_state[pos] == dht_pkg::SLOT_EMPTY ||
            model_state[pos] == dht_pkg::SLOT_REMOVED) begin
          model_state[pos]  = dht_pkg::SLOT_OCCUPIED;
          model_key[pos]    = dht_pkg::KEY_W'(key);
          model_name[pos]   = name;
          model_age[pos]    = age;
          model_weight[pos] = weight;
          model_height[pos] = height;
          res.status = dht_pkg::STATUS_OK;
          res.slot = SLOT_W'(pos);
          break;
        end
        pos = (pos + stride) % m;
      end
    end else if (op == dht_pkg::OP_SEARCH || op == dht_pkg::OP_REMOVE) begin
      // An empty slot ends the chain; removed slots are stepped over.
      hit = -1;
      for (i = 0; i < m; i++) begin
        if (model_state[pos] == dht_pkg::SLOT_EMPTY) break;
        if (model_state[pos] == dht_pkg::SLOT_OCCUPIED &&
            model_key[pos] == dht_pkg::KEY_W'(key) && model_name[pos] == name) begin
          hit = pos;
          break;
        end
        pos = (pos + stride) % m;
      end
      if (hit >= 0) begin
        res.status = dht_pkg::STATUS_OK;
        res.slot = SLOT_W'(hit);
        if (op == dht_pkg::OP_SEARCH) begin
          res.age    = model_age[hit];
          res.weight = model_weight[hit];
          res.height = model_height[hit];
        end else begin
          model_state[hit] = dht_pkg::SLOT_REMOVED;
        end
      end
    end
    return res;
  endfunction

  function automatic void add_req(
    input logic [dht_pkg::OP_W-1:0]        op,
    input logic [dht_pkg::NAME_WORD_W-1:0] name,
    input logic [dht_pkg::AGE_W-1:0]       age,
    input logic [dht_pkg::WEIGHT_W-1:0]    weight,
    input logic [dht_pkg::HEIGHT_W-1:0]    height,
    input logic                            typed = 1'b0,
    input hash_result_t                    res = '0
  );
    dir_row_t row;
    row = '0;
    row.kind   = ROW_REQUEST;
    row.op     = op;
    row.name   = name;
    row.age    = age;
    row.weight = weight;
    row.height = height;
    row.typed  = typed;
    row.res    = res;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_resize(input logic [dht_pkg::CFG_W-1:0] size);
    dir_row_t row;
    row = '0;
    row.kind = ROW_RESIZE;
    row.size = size;
    dir_rows.push_back(row);
  endfunction

  // Presents one request at a falling edge, after an optional random gap,
  // and holds it until the block takes it. The expectation is queued at the
  // accepting edge; a typed-in expectation overrides the shadow table's
  // answer, but the shadow table is still updated.
  task automatic send_request(
    input logic [dht_pkg::OP_W-1:0]        op,
    input logic [dht_pkg::NAME_WORD_W-1:0] name,
    input logic [dht_pkg::AGE_W-1:0]       age,
    input logic [dht_pkg::WEIGHT_W-1:0]    weight,
    input logic [dht_pkg::HEIGHT_W-1:0]    height,
    input logic                            typed,
    input hash_result_t                    typed_res
  );
    hash_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_opcode    = op;
    in_name_word = name;
    in_age_in    = age;
    in_weight_in = weight;
    in_height_in = height;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    res = predict_hash_result(op, name, age, weight, height);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // The sender stops and waits until every queued result has come back.
  // Every request yields a result, so an empty queue means an idle block.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Table size writes only happen with nothing in flight.
  task automatic write_table_size(input logic [dht_pkg::CFG_W-1:0] size);
    wait_for_drain();
    @(negedge clk);
    cfg_table_size = size;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    model_size = size;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side: out_ready is rolled at every falling edge, and a result is
  // taken and compared at the rising edge where valid and ready meet.
  initial begin
    hash_result_t got;
    hash_result_t want;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{out_status, out_slot_index, out_age_out, out_weight_out, out_height_out};
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: result with no request outstanding: status %0d slot %0d",
                   $time, got.status, got.slot);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            error_count++;
            $display("%0t: mismatch, expected status %0d slot %0d age %h weight %h height %h",
                     $time, want.status, want.slot, want.age, want.weight, want.height);
            $display("%0t:           actual status %0d slot %0d age %h weight %h height %h",
                     $time, got.status, got.slot, got.age, got.weight, got.height);
          end
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases.
  initial begin
    logic [dht_pkg::OP_W-1:0]        op;
    logic [dht_pkg::NAME_WORD_W-1:0] name;
    int                              nbytes;
    int                              pick;
    idle_mode_t                      mode;

    // Every input starts at a known value.
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_table_size = '0;
    in_valid       = 1'b0;
    in_opcode      = dht_pkg::OP_INSERT;
    in_name_word   = '0;
    in_age_in      = '0;
    in_weight_in   = '0;
    in_height_in   = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;

    model_size = dht_pkg::TABLE_SIZE_RESET;
    foreach (model_state[i]) begin
      model_state[i]  = dht_pkg::SLOT_EMPTY;
      model_key[i]    = '0;
      model_name[i]   = '0;
      model_age[i]    = '0;
      model_weight[i] = '0;
      model_height[i] = '0;
    end

    // The name pool makes searches and removes hit stored records. Every
    // third entry is a byte rotation of the one before: same key, other
    // name, so the name comparison is exercised on key collisions.
    foreach (name_pool[i]) begin
      if (i % 3 == 2) begin
        name_pool[i] = {name_pool[i-1][55:0], name_pool[i-1][63:56]};
      end else begin
        nbytes = $urandom_range(8, 1);
        name_pool[i] = {$urandom, $urandom} & (~64'h0 >> (8 * (8 - nbytes)));
      end
    end

    // Directed rows. The table starts at its reset size of 64 slots.
    // Lookups on the empty table and the unused opcode all miss.
    add_req(dht_pkg::OP_SEARCH, 64'h0, 8'h00, 32'h0, 32'h0, 1'b1,
            hash_result_t'{status: dht_pkg::STATUS_NOT_FOUND, default: '0});
    add_req(dht_pkg::OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 1'b1,
            hash_result_t'{status: dht_pkg::STATUS_NOT_FOUND, default: '0});
    add_req(OP_UNUSED, 64'h0123_4567_89AB_CDEF, 8'hA5, 32'h3F80_0000, 32'h4000_0000, 1'b1,
            hash_result_t'{status: dht_pkg::STATUS_NOT_FOUND, default: '0});
    // The all-zero name has key 0 and lands in slot 0.
    add_req(dht_pkg::OP_INSERT, 64'h0, 8'h00, 32'h0, 32'h0, 1'b1,
            hash_result_t'{status: dht_pkg::STATUS_OK, default: '0});
    add_req(dht_pkg::OP_SEARCH, 64'h0, 8'h00, 32'h0, 32'h0, 1'b1,
            hash_result_t'{status: dht_pkg::STATUS_OK, default: '0});
    // The all-ones name has key 2040, which is 56 mod 64.
    add_req(dht_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 1'b1,
            hash_result_t'{status: dht_pkg::STATUS_OK, slot: 6'd56, age: 8'h00,
                           weight: 32'h0, height: 32'h0});
    add_req(dht_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 32'h0, 32'h0, 1'b1,
            hash_result_t'{status: dht_pkg::STATUS_OK, slot: 6'd56, age: 8'hFF,
                           weight: 32'hFFFF_FFFF, height: 32'hFFFF_FFFF});
    // A duplicate insert goes to the next slot of the probe chain.
    add_req(dht_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h5A, 32'h1234_5678,
            32'h9ABC_DEF0);
    add_req(dht_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 32'h0, 32'h0);
    // Bytes after a zero byte still count; a rotated name shares the key.
    add_req(dht_pkg::OP_INSERT, 64'h4100_0000_0000_0041, 8'h11, 32'h4120_0000,
            32'h3FC0_0000);
    add_req(dht_pkg::OP_INSERT, 64'h0000_0000_0000_4141, 8'h22, 32'h4140_0000,
            32'h3FE0_0000);
    add_req(dht_pkg::OP_SEARCH, 64'h0000_0000_0000_4141, 8'h00, 32'h0, 32'h0);
    // Key 64 collides with the zero name in slot 0.
    add_req(dht_pkg::OP_INSERT, 64'h0000_0000_0000_0040, 8'h33, 32'h4248_0000,
            32'h4000_0000);
    add_req(dht_pkg::OP_REMOVE, 64'h0, 8'h00, 32'h0, 32'h0, 1'b1,
            hash_result_t'{status: dht_pkg::STATUS_OK, default: '0});
    // The removed slot does not match, and slot 1 after it is empty.
    add_req(dht_pkg::OP_SEARCH, 64'h0, 8'h00, 32'h0, 32'h0, 1'b1,
            hash_result_t'{status: dht_pkg::STATUS_NOT_FOUND, default: '0});
    // A search must step over the removed slot to find key 64.
    add_req(dht_pkg::OP_SEARCH, 64'h0000_0000_0000_0040, 8'h00, 32'h0, 32'h0);
    add_req(dht_pkg::OP_INSERT, 64'h0, 8'h44, 32'h0000_0001, 32'h8000_0000);
    // A size of zero acts as two slots; three inserts cannot all fit.
    add_resize(7'd0);
    add_req(dht_pkg::OP_INSERT, 64'h8000_0000_0000_0001, 8'h01, 32'hDEAD_BEEF,
            32'hCAFE_F00D);
    add_req(dht_pkg::OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFE, 8'h02, 32'h0BAD_F00D,
            32'h0000_FFFF);
    add_req(dht_pkg::OP_INSERT, 64'hF0F0_F0F0_0F0F_0F0F, 8'h03, 32'hFFFF_0000,
            32'h5555_AAAA, 1'b1,
            hash_result_t'{status: dht_pkg::STATUS_FULL, default: '0});
    add_req(dht_pkg::OP_SEARCH, 64'h0, 8'h00, 32'h0, 32'h0);
    // Above the slot count the size acts as 64 and old records reappear.
    add_resize(7'd127);
    add_req(dht_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 32'h0, 32'h0);
    add_req(dht_pkg::OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 32'h0, 32'h0);

    // Reset is held low and then released at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The first request waits out the clearing sweep through in_ready.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_RESIZE) begin
        write_table_size(dir_rows[r].size);
      end else begin
        send_request(dir_rows[r].op, dir_rows[r].name, dir_rows[r].age,
                     dir_rows[r].weight, dir_rows[r].height,
                     dir_rows[r].typed, dir_rows[r].res);
      end
    end

    // Random phases. Each one drains the block, sets a new size and then
    // runs under one idling pattern, so each pattern meets two size settings.
    for (int p = 0; p < PHASES; p++) begin
      write_table_size(phase_size[p]);
      mode = idle_mode_t'(p % 4);
      case (mode)
        IDLE_NONE: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        IDLE_SENDER: begin
          send_idle_pct  = 72;
          recv_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          send_idle_pct  = 0;
          recv_stall_pct = 72;
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mostly well-formed traffic on pooled names, with some noise.
        pick = $urandom_range(99);
        if (pick < 40) op = dht_pkg::OP_INSERT;
        else if (pick < 70) op = dht_pkg::OP_SEARCH;
        else if (pick < 94) op = dht_pkg::OP_REMOVE;
        else op = OP_UNUSED;
        if ($urandom_range(99) < 85) name = name_pool[$urandom_range(POOL_SIZE - 1)];
        else name = {$urandom, $urandom};
        send_request(op, name, dht_pkg::AGE_W'($urandom), $urandom, $urandom, 1'b0, '0);
      end
    end

    // Wind down: wait for every result, then watch for stray ones.
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("double_hash_table regression: pass");
    end else begin
      $display("double_hash_table regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #10_000_000;
    $display("double_hash_table regression: fail");
    $finish;
  end

endmodule
